// ===== design/generational_slot_allocator_defines.svh =====
// Assertion macros for the generational slot allocator.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define GSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define GSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GSA_ASSERT(lbl, prop, msg)
`define GSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/gsa_pkg.sv =====
// Shared types, codes and helpers of the generational slot allocator.
`default_nettype none

package gsa_pkg;

  localparam int unsigned DefSlotCount = 64;
  localparam int unsigned WordW        = 32;
  localparam int unsigned BitW         = 5;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CountW       = 7;
  localparam logic [CountW-1:0] CountMax = 7'd127;
  localparam logic [DataW-1:0]  AllOnes  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RESOLVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_BAD_GEN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ALLOC_GEN,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic              ok;
    status_e           status;
    logic [DataW-1:0]  index;
    logic [DataW-1:0]  generation;
    logic [CountW-1:0] live;
  } result_t;

  // Build a rejected result: both handle halves all ones.
  function automatic result_t fail_res(status_e st, logic [CountW-1:0] live);
    result_t r;
    r.ok         = 1'b0;
    r.status     = st;
    r.index      = AllOnes;
    r.generation = AllOnes;
    r.live       = live;
    return r;
  endfunction

  // Build a successful result.
  function automatic result_t ok_res(logic [DataW-1:0] idx, logic [DataW-1:0] gen,
                                     logic [CountW-1:0] live);
    result_t r;
    r.ok         = 1'b1;
    r.status     = STAT_OK;
    r.index      = idx;
    r.generation = gen;
    r.live       = live;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/generational_slot_allocator.sv =====
// Generational slot allocator: slot bitmap and generation memories with a request sequencer.
`default_nettype none

// One request at a time. Free and resolve pass ST_LOOKUP: the registered
// read of the slot bitmap word and the generation entry, then the compare
// and write back. Allocate goes on to ST_ALLOC_GEN: the bitmap word read
// picks the lowest free slot, and only then can that slot's generation be
// read. Rejected requests (table full, bad index, unknown action) finish
// in the transfer cycle. The slot bitmap is kept in 32-slot words with one
// full flag and one written flag per word, so no clearing pass is needed
// after reset; an unwritten word reads as all slots free with generation
// zero. Results sit in an output register, so the next request is taken
// while a finished result still waits downstream.
module generational_slot_allocator #(
  parameter int unsigned SLOT_COUNT = gsa_pkg::DefSlotCount
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [gsa_pkg::DataW-1:0]  handle_index_i,
  input  logic [gsa_pkg::DataW-1:0]  handle_generation_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic [1:0]                 status_o,
  output logic [gsa_pkg::DataW-1:0]  result_index_o,
  output logic [gsa_pkg::DataW-1:0]  result_generation_o,
  output logic [gsa_pkg::CountW-1:0] live_slots_o
);
  import gsa_pkg::*;

  `include "generational_slot_allocator_defines.svh"

  localparam int unsigned NumWords  = (SLOT_COUNT + WordW - 1) / WordW;
  localparam int unsigned WaddrW    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned WordDepth = 2 ** WaddrW;
  localparam int unsigned SlotW     = WaddrW + BitW;
  localparam int unsigned IdxW      = $clog2(SLOT_COUNT);

  // Control state
  state_e                state_q, state_d;
  logic [CountW-1:0]     live_q, live_d;
  logic [WordDepth-1:0]  word_full_q, word_full_d;
  logic [WordDepth-1:0]  word_vld_q, word_vld_d;
  logic                  out_valid_q, out_valid_d;

  // Request payload
  action_e               act_q, act_d;
  logic [SlotW-1:0]      idx_q, idx_d;
  logic [DataW-1:0]      hgen_q, hgen_d;
  result_t               res_q, res_d;
  result_t               out_q, out_d;

  // Memories: bitmap word holds {generation written bits, used bits}
  logic [2*WordW-1:0]    map_mem [WordDepth];
  logic [DataW-1:0]      gen_mem [SLOT_COUNT];
  logic [2*WordW-1:0]    map_rd_q;
  logic                  map_rd_vld_q;
  logic [DataW-1:0]      gen_rd_q;

  logic                  map_re, map_we;
  logic [WaddrW-1:0]     map_raddr, map_waddr;
  logic [2*WordW-1:0]    map_wdata;
  logic                  gen_re, gen_we;
  logic [IdxW-1:0]       gen_raddr, gen_waddr;
  logic [DataW-1:0]      gen_wdata;

  // Word decode
  logic [WaddrW-1:0]     cur_word;
  logic [BitW-1:0]       cur_bit;
  logic [2*WordW-1:0]    map_word;
  logic [WordW-1:0]      used_w, gw_w, pad_w, taken_w;
  logic [WordW-1:0]      cur_oh, sel_oh, used_new;
  logic [BitW-1:0]       bit_sel;
  logic                  bit_hit;
  logic [SlotW-1:0]      slot_b;
  logic [DataW-1:0]      gen_eff, gen_inc;
  logic [WaddrW-1:0]     wsel;
  logic                  wfound;
  logic [CountW-1:0]     live_inc, live_dec;

  logic                  out_free;
  logic                  fin;
  result_t               fin_res;

  assign cur_word = idx_q[SlotW-1:BitW];
  assign cur_bit  = idx_q[BitW-1:0];
  assign map_word = map_rd_vld_q ? map_rd_q : '0;
  assign used_w   = map_word[WordW-1:0];
  assign gw_w     = map_word[2*WordW-1:WordW];
  assign cur_oh   = WordW'(1) << cur_bit;
  assign gen_eff  = ((gw_w & cur_oh) != '0) ? gen_rd_q : '0;
  assign gen_inc  = gen_eff + DataW'(1);
  assign live_inc = (live_q == CountMax) ? live_q : live_q + CountW'(1);
  assign live_dec = (live_q == '0) ? live_q : live_q - CountW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // Mark slots past the end of the table as taken
  always_comb begin
    slot_b = '0;
    for (int b = 0; b < WordW; b++) begin
      slot_b   = {cur_word, BitW'(b)};
      pad_w[b] = (32'(slot_b) >= SLOT_COUNT);
    end
  end

  // Pick the lowest free slot of the fetched word
  always_comb begin
    taken_w = used_w | pad_w;
    bit_sel = '0;
    bit_hit = 1'b0;
    for (int b = 0; b < WordW; b++) begin
      if (!taken_w[b] && !bit_hit) begin
        bit_hit = 1'b1;
        bit_sel = BitW'(b);
      end
    end
    sel_oh   = WordW'(1) << bit_sel;
    used_new = used_w | sel_oh;
  end

  // Pick the lowest word with a free slot
  always_comb begin
    wsel   = '0;
    wfound = 1'b0;
    for (int w = 0; w < WordDepth; w++) begin
      if (!word_full_q[w] && !wfound) begin
        wfound = 1'b1;
        wsel   = WaddrW'(w);
      end
    end
  end

  // Sequencer: next state, memory accesses and results
  always_comb begin
    state_d     = state_q;
    live_d      = live_q;
    word_full_d = word_full_q;
    word_vld_d  = word_vld_q;
    act_d       = act_q;
    idx_d       = idx_q;
    hgen_d      = hgen_q;
    res_d       = res_q;
    map_re      = 1'b0;
    map_raddr   = '0;
    map_we      = 1'b0;
    map_waddr   = cur_word;
    map_wdata   = '0;
    gen_re      = 1'b0;
    gen_raddr   = '0;
    gen_we      = 1'b0;
    gen_waddr   = idx_q[IdxW-1:0];
    gen_wdata   = gen_inc;
    fin         = 1'b0;
    fin_res     = res_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            ACT_ALLOC: begin
              if (wfound) begin
                act_d     = ACT_ALLOC;
                idx_d     = {wsel, {BitW{1'b0}}};
                map_re    = 1'b1;
                map_raddr = wsel;
                state_d   = ST_LOOKUP;
              end else begin
                fin     = 1'b1;
                fin_res = fail_res(STAT_NO_FREE, live_q);
              end
            end
            ACT_FREE, ACT_RESOLVE: begin
              if (handle_index_i >= SLOT_COUNT) begin
                fin     = 1'b1;
                fin_res = fail_res(STAT_BAD_INDEX, live_q);
              end else begin
                act_d     = action_e'(action_i);
                idx_d     = handle_index_i[SlotW-1:0];
                hgen_d    = handle_generation_i;
                map_re    = 1'b1;
                map_raddr = handle_index_i[BitW +: WaddrW];
                gen_re    = 1'b1;
                gen_raddr = handle_index_i[IdxW-1:0];
                state_d   = ST_LOOKUP;
              end
            end
            default: begin
              fin     = 1'b1;
              fin_res = fail_res(STAT_BAD_INDEX, live_q);
            end
          endcase
        end
      end

      ST_LOOKUP: begin
        case (act_q)
          ACT_ALLOC: begin
            // Claim the slot, then fetch its generation
            idx_d                 = {cur_word, bit_sel};
            gen_re                = 1'b1;
            gen_raddr             = idx_d[IdxW-1:0];
            map_we                = 1'b1;
            map_wdata             = {gw_w, used_new};
            word_vld_d[cur_word]  = 1'b1;
            word_full_d[cur_word] = &(used_new | pad_w);
            live_d                = live_inc;
            state_d               = ST_ALLOC_GEN;
          end
          ACT_FREE: begin
            // Retire the slot and bump its generation
            gen_we                = 1'b1;
            map_we                = 1'b1;
            map_wdata             = {gw_w | cur_oh, used_w & ~cur_oh};
            word_vld_d[cur_word]  = 1'b1;
            word_full_d[cur_word] = 1'b0;
            live_d                = live_dec;
            fin                   = 1'b1;
            fin_res               = ok_res(DataW'(idx_q), gen_inc, live_dec);
          end
          default: begin
            fin = 1'b1;
            if (hgen_q == AllOnes || gen_eff != hgen_q) begin
              fin_res = fail_res(STAT_BAD_GEN, live_q);
            end else begin
              fin_res = ok_res(DataW'(idx_q), hgen_q, live_q);
            end
          end
        endcase
      end

      ST_ALLOC_GEN: begin
        fin     = 1'b1;
        fin_res = ok_res(DataW'(idx_q), gen_eff, live_q);
      end

      ST_WAIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Hand the result to the output register, or park it
    if (fin) begin
      if (out_free) begin
        state_d = ST_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = ST_WAIT;
      end
    end
  end

  // Output register load and drain
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fin && out_free) begin
      out_d       = fin_res;
      out_valid_d = 1'b1;
    end else if (state_q == ST_WAIT && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= '0;
      word_vld_q  <= '0;
      out_valid_q <= 1'b0;
      for (int w = 0; w < WordDepth; w++) begin
        word_full_q[w] <= (w >= NumWords);
      end
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      word_full_q <= word_full_d;
      word_vld_q  <= word_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    idx_q  <= idx_d;
    hgen_q <= hgen_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // Slot bitmap memory
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rd_q     <= map_mem[map_raddr];
      map_rd_vld_q <= word_vld_q[map_raddr];
    end
  end

  // Generation memory
  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (gen_re) begin
      gen_rd_q <= gen_mem[gen_raddr];
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign ok_o                = out_q.ok;
  assign status_o            = out_q.status;
  assign result_index_o      = out_q.index;
  assign result_generation_o = out_q.generation;
  assign live_slots_o        = out_q.live;

  // Checks
  `GSA_ASSERT(a_live_step,
    live_q == $past(live_q) || live_q == $past(live_q) + 7'd1 || live_q == $past(live_q) - 7'd1,
    "live count moved by more than one")
  `GSA_ASSERT(a_ok_status, !out_valid_o || (ok_o == (status_o == STAT_OK)),
    "ok flag disagrees with status")
  `GSA_ASSERT(a_fail_ones,
    !(out_valid_o && !ok_o) || (result_index_o == AllOnes && result_generation_o == AllOnes),
    "failed result carries a handle")
  `GSA_ASSERT(a_ok_range, !(out_valid_o && ok_o) || (result_index_o < SLOT_COUNT),
    "successful result index out of range")

endmodule

`default_nettype wire

// ===== dv/tb_generational_slot_allocator.sv =====
// Self-checking testbench for the generational slot allocator: directed and random handle traffic.
module tb_generational_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import gsa_pkg::*;

  localparam int unsigned Slots       = DefSlotCount;
  localparam logic [1:0]  ActUnknown  = 2'd3;
  localparam int          RandomItems = 700;
  localparam int          PhaseLen    = 100;
  localparam int          DrainCycles = 10;
  localparam int          CycleLimit  = 400000;
  localparam int          MaxReported = 10;

  // Slot table mirror and queue of results still owed by the block
  class slot_scoreboard;
    bit                used [Slots];
    logic [DataW-1:0]  gen  [Slots];
    logic [CountW-1:0] live;
    result_t           pending [$];
    int                errors;
    int                reported;

    function new();
      foreach (used[i]) begin
        used[i] = 1'b0;
        gen[i]  = '0;
      end
      live     = '0;
      errors   = 0;
      reported = 0;
    endfunction

    function result_t rejected(status_e st);
      result_t r;
      r.ok         = 1'b0;
      r.status     = st;
      r.index      = AllOnes;
      r.generation = AllOnes;
      r.live       = '0;
      return r;
    endfunction

    // Apply one accepted request to the mirror and queue the result it owes
    function void note_request(logic [1:0] act, logic [DataW-1:0] idx,
                               logic [DataW-1:0] hgen);
      result_t r;
      bit      found;
      r     = rejected(STAT_BAD_INDEX);
      found = 1'b0;
      case (act)
        ACT_ALLOC: begin
          r = rejected(STAT_NO_FREE);
          for (int i = 0; i < Slots; i++) begin
            if (!found && !used[i]) begin
              found   = 1'b1;
              used[i] = 1'b1;
              if (live != CountMax) live++;
              r.ok         = 1'b1;
              r.status     = STAT_OK;
              r.index      = i;
              r.generation = gen[i];
            end
          end
        end
        ACT_FREE, ACT_RESOLVE: begin
          if (idx < Slots) begin
            if (act == ACT_FREE) begin
              // Retire the slot even when it is already free
              used[idx] = 1'b0;
              gen[idx]  = gen[idx] + 1;
              if (live != 0) live--;
              r.ok         = 1'b1;
              r.status     = STAT_OK;
              r.index      = idx;
              r.generation = gen[idx];
            end else if (hgen == AllOnes || gen[idx] != hgen) begin
              r = rejected(STAT_BAD_GEN);
            end else begin
              r.ok         = 1'b1;
              r.status     = STAT_OK;
              r.index      = idx;
              r.generation = hgen;
            end
          end
        end
        default: begin
          r = rejected(STAT_BAD_INDEX);
        end
      endcase
      r.live = live;
      pending.push_back(r);
    endfunction

    // Compare one result transfer against the oldest pending result
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (reported < MaxReported) begin
          reported++;
          $display("ERROR: unexpected result ok=%0b status=%0d idx=%h gen=%h live=%0d",
                   got.ok, got.status, got.index, got.generation, got.live);
        end
        return;
      end
      want = pending.pop_front();
      if (got.ok != want.ok || got.status != want.status || got.index != want.index ||
          got.generation != want.generation || got.live != want.live) begin
        errors++;
        if (reported < MaxReported) begin
          reported++;
          $display("ERROR: exp ok=%0b status=%0d idx=%h gen=%h live=%0d",
                   want.ok, want.status, want.index, want.generation, want.live);
          $display("       got ok=%0b status=%0d idx=%h gen=%h live=%0d",
                   got.ok, got.status, got.index, got.generation, got.live);
        end
      end
    endfunction
  endclass

  logic              clk_i               = 1'b0;
  logic              rst_ni              = 1'b0;
  logic              in_valid_i          = 1'b0;
  logic              in_stall_o;
  logic [1:0]        action_i            = ACT_ALLOC;
  logic [DataW-1:0]  handle_index_i      = '0;
  logic [DataW-1:0]  handle_generation_i = '0;
  logic              out_valid_o;
  logic              out_stall_i         = 1'b0;
  logic              ok_o;
  logic [1:0]        status_o;
  logic [DataW-1:0]  result_index_o;
  logic [DataW-1:0]  result_generation_o;
  logic [CountW-1:0] live_slots_o;

  slot_scoreboard sb = new();
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  int             cycle_count = 0;

  generational_slot_allocator #(
    .SLOT_COUNT(Slots)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .handle_index_i     (handle_index_i),
    .handle_generation_i(handle_generation_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .ok_o               (ok_o),
    .status_o           (status_o),
    .result_index_o     (result_index_o),
    .result_generation_o(result_generation_o),
    .live_slots_o       (live_slots_o)
  );

  always #1 clk_i = ~clk_i;

  // Hold the result channel in random stall bursts
  always @(posedge clk_i) begin
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      stall_left  = $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.ok         = ok_o;
      got.status     = status_e'(status_o);
      got.index      = result_index_o;
      got.generation = result_generation_o;
      got.live       = live_slots_o;
      sb.check_result(got);
    end
  end

  // Drive one request until its transfer, then maybe drop valid for a burst
  task automatic send_request(logic [1:0] act, logic [DataW-1:0] idx,
                              logic [DataW-1:0] hgen);
    in_valid_i          <= 1'b1;
    action_i            <= act;
    handle_index_i      <= idx;
    handle_generation_i <= hgen;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(act, idx, hgen);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Mostly in-range indexes, some just past the table, some invalid or wild
  function automatic logic [DataW-1:0] random_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(0, Slots - 1);
    if (roll < 90) return $urandom_range(Slots, Slots + 3);
    if (roll < 95) return AllOnes;
    return $urandom();
  endfunction

  // Stop a hung run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int               alloc_w;
    int               free_w;
    int               roll;
    int               start;
    int               j;
    logic [1:0]       act;
    logic [DataW-1:0] idx;
    logic [DataW-1:0] hgen;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: empty-table free, stale and invalid handles, bad actions
    tx_idle_pct = 15;
    rx_idle_pct = 15;
    send_request(ACT_FREE, 32'd5, 32'd0);
    send_request(ACT_ALLOC, 32'd0, 32'd0);
    send_request(ACT_ALLOC, AllOnes, AllOnes);
    send_request(ACT_RESOLVE, 32'd0, 32'd0);
    send_request(ACT_RESOLVE, 32'd0, AllOnes);
    send_request(ACT_RESOLVE, 32'd1, 32'd7);
    send_request(ACT_RESOLVE, 32'd5, 32'd1);
    send_request(ACT_RESOLVE, AllOnes, 32'd0);
    send_request(ACT_FREE, Slots, 32'd0);
    send_request(ACT_FREE, AllOnes, 32'd0);
    send_request(ACT_RESOLVE, 32'h8000_0000, 32'd0);
    send_request(ActUnknown, 32'd0, 32'd0);
    send_request(ActUnknown, AllOnes, AllOnes);
    send_request(ACT_FREE, 32'd0, AllOnes);
    send_request(ACT_RESOLVE, 32'd0, 32'd0);
    send_request(ACT_ALLOC, 32'd0, 32'd0);
    send_request(ACT_RESOLVE, 32'd0, 32'd1);
    send_request(ACT_FREE, Slots - 1, 32'hFFFF_FFFE);
    send_request(ACT_RESOLVE, Slots - 1, 32'd1);
    send_request(ACT_RESOLVE, Slots, 32'd0);

    // Random phases: fill to full, drain, and mixed traffic
    alloc_w = 80;
    free_w  = 5;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % PhaseLen == 0) begin
        if (n >= RandomItems - PhaseLen) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end else begin
          roll        = $urandom_range(2);
          tx_idle_pct = (roll == 0) ? 0 : (roll == 1) ? 8 : 25;
          roll        = $urandom_range(2);
          rx_idle_pct = (roll == 0) ? 0 : (roll == 1) ? 8 : 25;
        end
        if (n != 0) begin
          roll = $urandom_range(2);
          case (roll)
            0:       begin alloc_w = 80; free_w = 5;  end
            1:       begin alloc_w = 15; free_w = 60; end
            default: begin alloc_w = 35; free_w = 30; end
          endcase
        end
      end

      roll = $urandom_range(99);
      if (roll < alloc_w) act = ACT_ALLOC;
      else if (roll < alloc_w + free_w) act = ACT_FREE;
      else if (roll < 97) act = ACT_RESOLVE;
      else act = ActUnknown;

      idx  = random_index();
      hgen = $urandom();

      // Aim most frees at live slots
      if (act == ACT_FREE && $urandom_range(99) < 70) begin
        start = $urandom_range(Slots - 1);
        for (int k = 0; k < Slots; k++) begin
          j = (start + k) % Slots;
          if (sb.used[j]) begin
            idx = j;
            break;
          end
        end
      end

      // Mix current, stale and invalid generations on resolve
      if (act == ACT_RESOLVE && idx < Slots) begin
        roll = $urandom_range(99);
        if (roll < 55) hgen = sb.gen[idx];
        else if (roll < 75) hgen = sb.gen[idx] - 1;
        else if (roll < 85) hgen = AllOnes;
      end

      send_request(act, idx, hgen);
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
